[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LSI_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LSI_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LSI_ASSERT_IMP(name, clk, rst, ante, cons)
`define LSI_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

[hdl/lsi_pkg.sv]
// ---------------------------------------------------------------------------
// lsi_pkg
// Widths, codes and beat types of the segment intersection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package lsi_pkg;
   localparam int CW = 32;          // coordinate
   localparam int DW = CW + 1;      // coordinate difference
   localparam int PW = 2 * DW;      // 33x33 product
   localparam int NW = PW + 1;      // det / numerators
   localparam int QW = 34;          // quotient bits resolved
   localparam int LW = QW + DW + 1; // low partial product
   localparam int MW = NW + QW;     // scaled numerator
   localparam int VW = QW + 3;      // final sum
   localparam int REQ_W = 8 * CW;
   localparam int RSP_W = 72;

   localparam logic signed [NW-1:0] DET_EPS = NW'(4294967);
   localparam logic signed [DW-1:0] EXT_EPS = DW'(65);
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef enum logic [1:0] {
      OUT_HIT      = 2'd0,
      OUT_PARALLEL = 2'd1,
      OUT_OUTSIDE  = 2'd2
   } outcome_type;

   typedef struct packed {
      logic                 neg;
      logic                 ovf;
      logic [NW-1:0]        rem;
      logic [QW-1:0]        low;
      logic [QW-1:0]        quo;
      logic signed [CW-1:0] base;
   } lane_type;

   typedef struct packed {
      outcome_type   outcome;
      logic [NW-1:0] dm;
      lane_type      lx;
      lane_type      ly;
   } beat_type;
endpackage
`default_nettype wire

[hdl/lsi_geom.sv]
// ---------------------------------------------------------------------------
// lsi_geom
// Seven-stage front: differences, cross products, classification and
// scaled numerators ready for the divider.
// ---------------------------------------------------------------------------
`default_nettype none
module lsi_geom (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        mode,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [lsi_pkg::REQ_W-1:0]   in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output lsi_pkg::beat_type                out_beat
);
   import lsi_pkg::*;

   localparam int NS = 7;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   // stage A
   logic signed [DW-1:0] a_d1x_ff, a_d1y_ff, a_d2x_ff, a_d2y_ff, a_ex_ff, a_ey_ff;
   logic signed [CW-1:0] a_x0_ff, a_y0_ff;
   // stage B
   logic signed [PW-1:0] b_dt1_ff, b_dt2_ff, b_nt1_ff, b_nt2_ff, b_nu1_ff, b_nu2_ff;
   logic                 b_tiny1_ff, b_tiny2_ff;
   logic signed [DW-1:0] b_d1x_ff, b_d1y_ff;
   logic signed [CW-1:0] b_x0_ff, b_y0_ff;
   // stage C
   logic signed [NW-1:0] c_det_ff, c_nt_ff, c_nu_ff;
   logic                 c_tiny1_ff, c_tiny2_ff;
   logic signed [DW-1:0] c_d1x_ff, c_d1y_ff;
   logic signed [CW-1:0] c_x0_ff, c_y0_ff;
   // stage D
   outcome_type          d_out_ff, d_out_in;
   logic signed [LW-1:0] d_lx_ff, d_ly_ff;
   logic signed [PW-1:0] d_hx_ff, d_hy_ff;
   logic [NW-1:0]        d_dm_ff;
   logic                 d_dneg_ff;
   logic signed [CW-1:0] d_x0_ff, d_y0_ff;
   // stage E
   outcome_type          e_out_ff;
   logic signed [MW-1:0] e_px_ff, e_py_ff;
   logic [NW-1:0]        e_dm_ff;
   logic                 e_dneg_ff;
   logic signed [CW-1:0] e_x0_ff, e_y0_ff;
   // stage F
   outcome_type          f_out_ff;
   logic [MW-1:0]        f_pmx_ff, f_pmy_ff;
   logic                 f_negx_ff, f_negy_ff;
   logic [NW-1:0]        f_dm_ff;
   logic signed [CW-1:0] f_x0_ff, f_y0_ff;
   // stage G
   beat_type             g_beat_ff, g_beat_in;

   logic signed [CW-1:0] fx0, fy0, fx1, fy1, fx2, fy2, fx3, fy3;

   function automatic logic in_unit(logic signed [NW-1:0] n, logic signed [NW-1:0] d);
      if (d[NW-1])
         return (n <= 0) && (n >= d);
      return (n >= 0) && (n <= d);
   endfunction

   function automatic logic tiny(logic signed [DW-1:0] dx, logic signed [DW-1:0] dy);
      return (dx <= EXT_EPS) && (dx >= -EXT_EPS) && (dy <= EXT_EPS) && (dy >= -EXT_EPS);
   endfunction

   function automatic lane_type mk_lane(logic [MW-1:0] pm, logic neg,
                                        logic [NW-1:0] dm, logic signed [CW-1:0] base);
      lane_type l;
      l.neg  = neg;
      l.rem  = pm[MW-1:QW];
      l.ovf  = (pm[MW-1:QW] >= dm);
      l.low  = pm[QW-1:0];
      l.quo  = '0;
      l.base = base;
      return l;
   endfunction

   assign fx0 = in_data[0*CW +: CW];
   assign fy0 = in_data[1*CW +: CW];
   assign fx1 = in_data[2*CW +: CW];
   assign fy1 = in_data[3*CW +: CW];
   assign fx2 = in_data[4*CW +: CW];
   assign fy2 = in_data[5*CW +: CW];
   assign fx3 = in_data[6*CW +: CW];
   assign fy3 = in_data[7*CW +: CW];

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--)
         rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];
   assign out_beat  = g_beat_ff;

   always_comb begin
      logic ok_a, ok_b;
      ok_a = !c_tiny1_ff && in_unit(c_nt_ff, c_det_ff);
      ok_b = !c_tiny2_ff && in_unit(c_nu_ff, c_det_ff);
      if ((c_det_ff <= DET_EPS) && (c_det_ff >= -DET_EPS))
         d_out_in = OUT_PARALLEL;
      else if (mode && !(ok_a && ok_b))
         d_out_in = OUT_OUTSIDE;
      else
         d_out_in = OUT_HIT;
   end

   always_comb begin
      g_beat_in.outcome = f_out_ff;
      g_beat_in.dm      = f_dm_ff;
      g_beat_in.lx      = mk_lane(f_pmx_ff, f_negx_ff, f_dm_ff, f_x0_ff);
      g_beat_in.ly      = mk_lane(f_pmy_ff, f_negy_ff, f_dm_ff, f_y0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0])
            vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++)
            if (rdy[k])
               vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_d1x_ff <= DW'(fx1) - DW'(fx0);
         a_d1y_ff <= DW'(fy1) - DW'(fy0);
         a_d2x_ff <= DW'(fx3) - DW'(fx2);
         a_d2y_ff <= DW'(fy3) - DW'(fy2);
         a_ex_ff  <= DW'(fx2) - DW'(fx0);
         a_ey_ff  <= DW'(fy2) - DW'(fy0);
         a_x0_ff  <= fx0;
         a_y0_ff  <= fy0;
      end
      if (rdy[1]) begin
         b_dt1_ff   <= a_d1x_ff * a_d2y_ff;
         b_dt2_ff   <= a_d1y_ff * a_d2x_ff;
         b_nt1_ff   <= a_ex_ff * a_d2y_ff;
         b_nt2_ff   <= a_ey_ff * a_d2x_ff;
         b_nu1_ff   <= a_ex_ff * a_d1y_ff;
         b_nu2_ff   <= a_ey_ff * a_d1x_ff;
         b_tiny1_ff <= tiny(a_d1x_ff, a_d1y_ff);
         b_tiny2_ff <= tiny(a_d2x_ff, a_d2y_ff);
         b_d1x_ff   <= a_d1x_ff;
         b_d1y_ff   <= a_d1y_ff;
         b_x0_ff    <= a_x0_ff;
         b_y0_ff    <= a_y0_ff;
      end
      if (rdy[2]) begin
         c_det_ff   <= NW'(b_dt1_ff) - NW'(b_dt2_ff);
         c_nt_ff    <= NW'(b_nt1_ff) - NW'(b_nt2_ff);
         c_nu_ff    <= NW'(b_nu1_ff) - NW'(b_nu2_ff);
         c_tiny1_ff <= b_tiny1_ff;
         c_tiny2_ff <= b_tiny2_ff;
         c_d1x_ff   <= b_d1x_ff;
         c_d1y_ff   <= b_d1y_ff;
         c_x0_ff    <= b_x0_ff;
         c_y0_ff    <= b_y0_ff;
      end
      if (rdy[3]) begin
         d_out_ff  <= d_out_in;
         // nt split into unsigned low and signed high halves
         d_lx_ff   <= $signed({1'b0, c_nt_ff[QW-1:0]}) * c_d1x_ff;
         d_ly_ff   <= $signed({1'b0, c_nt_ff[QW-1:0]}) * c_d1y_ff;
         d_hx_ff   <= $signed(c_nt_ff[NW-1:QW]) * c_d1x_ff;
         d_hy_ff   <= $signed(c_nt_ff[NW-1:QW]) * c_d1y_ff;
         d_dm_ff   <= c_det_ff[NW-1] ? NW'(-c_det_ff) : c_det_ff;
         d_dneg_ff <= c_det_ff[NW-1];
         d_x0_ff   <= c_x0_ff;
         d_y0_ff   <= c_y0_ff;
      end
      if (rdy[4]) begin
         e_out_ff  <= d_out_ff;
         e_px_ff   <= (MW'(d_hx_ff) <<< QW) + MW'(d_lx_ff);
         e_py_ff   <= (MW'(d_hy_ff) <<< QW) + MW'(d_ly_ff);
         e_dm_ff   <= d_dm_ff;
         e_dneg_ff <= d_dneg_ff;
         e_x0_ff   <= d_x0_ff;
         e_y0_ff   <= d_y0_ff;
      end
      if (rdy[5]) begin
         f_out_ff  <= e_out_ff;
         f_pmx_ff  <= e_px_ff[MW-1] ? MW'(-e_px_ff) : e_px_ff;
         f_pmy_ff  <= e_py_ff[MW-1] ? MW'(-e_py_ff) : e_py_ff;
         f_negx_ff <= e_px_ff[MW-1] ^ e_dneg_ff;
         f_negy_ff <= e_py_ff[MW-1] ^ e_dneg_ff;
         f_dm_ff   <= e_dm_ff;
         f_x0_ff   <= e_x0_ff;
         f_y0_ff   <= e_y0_ff;
      end
      if (rdy[6])
         g_beat_ff <= g_beat_in;
   end
endmodule
`default_nettype wire

[hdl/lsi_div.sv]
// ---------------------------------------------------------------------------
// lsi_div
// Restoring divider, one quotient bit per stage for both coordinates,
// then floor, offset and saturation into the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module lsi_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  lsi_pkg::beat_type                in_beat,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output lsi_pkg::outcome_type             out_outcome,
   output logic signed [lsi_pkg::CW-1:0]    out_x,
   output logic signed [lsi_pkg::CW-1:0]    out_y
);
   import lsi_pkg::*;

   logic [QW-1:0] vld_ff;
   logic [QW:0]   rdy;
   beat_type      stg_ff [QW];
   beat_type      stg_in [QW];
   logic          res_v_ff;
   outcome_type   res_out_ff;
   logic signed [CW-1:0] res_x_ff, res_y_ff;
   beat_type      last;

   function automatic lane_type div_step(lane_type l, logic [NW-1:0] dm);
      lane_type r;
      logic [NW:0] sh;
      logic [NW:0] df;
      r  = l;
      sh = {l.rem, l.low[QW-1]};
      df = sh - {1'b0, dm};
      if (sh >= {1'b0, dm}) begin
         r.rem = df[NW-1:0];
         r.quo = {l.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = sh[NW-1:0];
         r.quo = {l.quo[QW-2:0], 1'b0};
      end
      r.low = {l.low[QW-2:0], 1'b0};
      return r;
   endfunction

   function automatic logic signed [CW-1:0] place(lane_type l);
      logic signed [QW+1:0] f;
      logic signed [VW-1:0] v;
      f = l.neg ? (-$signed({2'b00, l.quo}) - $signed({{(QW+1){1'b0}}, |l.rem}))
                : $signed({2'b00, l.quo});
      v = VW'(l.base) + VW'(f);
      if (l.ovf)
         return l.neg ? C_MIN : C_MAX;
      if (v > VW'(C_MAX))
         return C_MAX;
      if (v < VW'(C_MIN))
         return C_MIN;
      return v[CW-1:0];
   endfunction

   always_comb begin
      rdy[QW] = !res_v_ff || out_ready;
      for (int k = QW - 1; k >= 0; k--)
         rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   always_comb begin
      stg_in[0] = in_beat;
      for (int k = 1; k < QW; k++)
         stg_in[k] = stg_ff[k-1];
      for (int k = 0; k < QW; k++) begin
         stg_in[k].lx = div_step(stg_in[k].lx, stg_in[k].dm);
         stg_in[k].ly = div_step(stg_in[k].ly, stg_in[k].dm);
      end
   end

   assign last      = stg_ff[QW-1];
   assign in_ready  = rdy[0];
   assign out_valid = res_v_ff;
   assign out_outcome = res_out_ff;
   assign out_x     = res_x_ff;
   assign out_y     = res_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         res_v_ff <= 1'b0;
      end else begin
         if (rdy[0])
            vld_ff[0] <= in_valid;
         for (int k = 1; k < QW; k++)
            if (rdy[k])
               vld_ff[k] <= vld_ff[k-1];
         if (rdy[QW])
            res_v_ff <= vld_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++)
         if (rdy[k])
            stg_ff[k] <= stg_in[k];
      if (rdy[QW]) begin
         res_out_ff <= last.outcome;
         // no point reported unless the outcome is a hit
         res_x_ff   <= (last.outcome == OUT_HIT) ? place(last.lx) : '0;
         res_y_ff   <= (last.outcome == OUT_HIT) ? place(last.ly) : '0;
      end
   end
endmodule
`default_nettype wire

[hdl/line_segment_intersection.sv]
// ---------------------------------------------------------------------------
// line_segment_intersection
// Intersection of two 2D segments or lines, Q16.16 in and out.
// ---------------------------------------------------------------------------
//   channel | dir | payload
//   req_    | in  | eight Q16.16 coordinates, 256-bit tdata
//   rsp_    | out | outcome, cross_x, cross_y, 72-bit tdata
//   csr_    | in  | segment_mode write
//
// One beat per cycle when not stalled; depth: 7 geometry stages, 34 divider
// stages, one result register. The divider, one quotient bit per stage,
// sets the depth. Synchronous reset clears all valid bits and sets
// segment_mode. Stalls ripple back combinationally; bubbles are squeezed out.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module line_segment_intersection (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
   // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
   input  wire logic [lsi_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // outcome [1:0], cross_x [33:2], cross_y [65:34], zero pad
   output logic [lsi_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic                        csr_wdata
);
   import lsi_pkg::*;

   logic        mode_ff;
   logic        g_valid, g_ready;
   beat_type    g_beat;
   outcome_type r_out;
   logic signed [CW-1:0] r_x, r_y;

   always_ff @(posedge clock) begin
      if (reset)
         mode_ff <= 1'b1;
      else if (csr_we)
         mode_ff <= csr_wdata;
   end

   lsi_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (g_valid),
      .out_ready (g_ready),
      .out_beat  (g_beat)
   );

   lsi_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (g_valid),
      .in_ready    (g_ready),
      .in_beat     (g_beat),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_outcome (r_out),
      .out_x       (r_x),
      .out_y       (r_y)
   );

   assign rsp_tdata = {{(RSP_W - 2 - 2 * CW){1'b0}}, r_y, r_x, r_out};

   `LSI_ASSERT_IMP(a_ready_unless_stalled, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
   `LSI_ASSERT_IMP(a_no_point_on_miss, clock, reset, rsp_tvalid && (r_out != OUT_HIT), (r_x == '0) && (r_y == '0))
   `LSI_ASSERT_IMP(a_outcome_code, clock, reset, rsp_tvalid, (r_out == OUT_HIT) || (r_out == OUT_PARALLEL) || (r_out == OUT_OUTSIDE))
   `LSI_ASSERT_NXT(a_csr_write, clock, reset, csr_we, mode_ff == $past(csr_wdata))
endmodule
`default_nettype wire

[tb/line_segment_intersection_test.sv]
// ---------------------------------------------------------------------------
// line_segment_intersection_test
// Self-checking bench for the segment intersection pipeline.
// Directed queries, and random ones under three stall patterns, are streamed
// in both segment and line mode. Each query is solved again in wide
// exact integers, and the expected beats are compared field by field with
// the response stream.
// ---------------------------------------------------------------------------
`default_nettype none
module line_segment_intersection_test;
   import lsi_pkg::*;

   typedef logic signed [127:0]  wide_type;
   typedef logic signed [31:0]   coord_type;
   typedef coord_type            query_type [8];

   typedef struct {
      outcome_type outcome;
      coord_type   x;
      coord_type   y;
   } crossing_type;

   localparam longint QUOT_CAP    = 64'h100_0000_0000;
   localparam int     DET_LIMIT   = 4294967;
   localparam int     EXTENT_MIN  = 65;
   localparam int     PIPE_DRAIN  = 60;
   localparam int     STALL_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we = 1'b0;
   logic               csr_wdata = 1'b0;

   crossing_type pending_crossings [$];
   bit        seg_mode = 1'b1;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        error_count = 0;
   int        query_count = 0;
   int        hit_count = 0;
   int        parallel_count = 0;
   int        outside_count = 0;
   int        quiet_cycles = 0;

   line_segment_intersection uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---- exact solver ----
   function automatic wide_type cross_product(longint ax, longint ay, longint bx, longint by);
      wide_type wax, way, wbx, wby;
      wax = ax; way = ay; wbx = bx; wby = by;
      return wax * wby - way * wbx;
   endfunction

   // base + floor(k * num / den), saturated to 32 bits
   function automatic coord_type place_coord(longint base, longint k, wide_type num,
                                             wide_type den);
      wide_type wk, p, ap, ad, q;
      bit       neg, rem_nz;
      longint   qm, v;
      wk = k;
      p = num * wk;
      neg = (p < 0) != (den < 0);
      ap = (p < 0) ? -p : p;
      ad = (den < 0) ? -den : den;
      q = ap / ad;
      rem_nz = (ap % ad) != 0;
      if (p == 0) neg = 1'b0;
      qm = (q > QUOT_CAP) ? QUOT_CAP : longint'(q);
      v = base + (neg ? -qm - (rem_nz ? 1 : 0) : qm);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return coord_type'(v);
   endfunction

   function automatic bit param_in_unit(wide_type num, wide_type den);
      if (den < 0) return num <= 0 && num >= den;
      return num >= 0 && num <= den;
   endfunction

   function automatic bit extent_tiny(longint dx, longint dy);
      return dx <= EXTENT_MIN && dx >= -EXTENT_MIN && dy <= EXTENT_MIN && dy >= -EXTENT_MIN;
   endfunction

   function automatic crossing_type solve_crossing(query_type q, bit on_segments);
      crossing_type r;
      longint       d1x, d1y, d2x, d2y, ex, ey;
      wide_type     det, nt, nu, adet;
      d1x = longint'(q[2]) - q[0];  d1y = longint'(q[3]) - q[1];
      d2x = longint'(q[6]) - q[4];  d2y = longint'(q[7]) - q[5];
      ex  = longint'(q[4]) - q[0];  ey  = longint'(q[5]) - q[1];
      det = cross_product(d1x, d1y, d2x, d2y);
      r.outcome = OUT_PARALLEL; r.x = '0; r.y = '0;
      adet = (det < 0) ? -det : det;
      if (adet <= DET_LIMIT) return r;
      nt = cross_product(ex, ey, d2x, d2y);
      nu = cross_product(ex, ey, d1x, d1y);
      if (on_segments && !(!extent_tiny(d1x, d1y) && param_in_unit(nt, det)
                           && !extent_tiny(d2x, d2y) && param_in_unit(nu, det))) begin
         r.outcome = OUT_OUTSIDE;
         return r;
      end
      r.outcome = OUT_HIT;
      r.x = place_coord(q[0], d1x, nt, det);
      r.y = place_coord(q[1], d1y, nt, det);
      return r;
   endfunction

   // ---- driver ----
   task automatic send_query(query_type q);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      for (int i = 0; i < 8; i++) req_tdata[32*i +: 32] = q[i];
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_crossings.push_back(solve_crossing(q, seg_mode));
      query_count++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_crossings.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic write_mode(bit mode);
      wait_idle();
      csr_we = 1'b1;
      csr_wdata = mode;
      @(negedge clock);
      csr_we = 1'b0;
      seg_mode = mode;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // ---- response checker ----
   always @(posedge clock) begin
      crossing_type want;
      outcome_type  got_outcome;
      coord_type    got_x, got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_outcome = outcome_type'(rsp_tdata[1:0]);
         got_x = rsp_tdata[33:2];
         got_y = rsp_tdata[65:34];
         if (pending_crossings.size() == 0) begin
            $display("%0t: unexpected beat outcome=%0d x=%h y=%h",
                     $time, got_outcome, got_x, got_y);
            error_count++;
         end else begin
            want = pending_crossings.pop_front();
            case (want.outcome)
               OUT_HIT:      hit_count++;
               OUT_PARALLEL: parallel_count++;
               default:      outside_count++;
            endcase
            if (got_outcome != want.outcome) begin
               $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                        got_outcome);
               error_count++;
            end
            if (got_x != want.x) begin
               $display("%0t: cross_x expected %h actual %h", $time, want.x, got_x);
               error_count++;
            end
            if (got_y != want.y) begin
               $display("%0t: cross_y expected %h actual %h", $time, want.y, got_y);
               error_count++;
            end
         end
      end
   end

   // watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else if (!reset && (req_tvalid || pending_crossings.size() != 0))
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d beats outstanding", $time, pending_crossings.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---- stimulus ----
   function automatic coord_type near_coord();
      return coord_type'(($urandom_range(16) - 8) * 65536 + $urandom_range(65535) - 32768);
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic void random_query(output query_type q);
      int     kind, m;
      for (int i = 0; i < 8; i++) q[i] = near_coord();
      kind = $urandom_range(9);
      case (kind)
         5: for (int i = 0; i < 8; i++) q[i] = coord_type'($urandom);
         6: begin  // parallel or collinear
            m = $urandom_range(3) - 1;
            q[6] = q[4] + m * (q[2] - q[0]);
            q[7] = q[5] + m * (q[3] - q[1]) + $urandom_range(2) - 1;
         end
         7: begin  // one segment shrunk to near a point
            q[2] = q[0] + $urandom_range(130) - 65;
            q[3] = q[1] + $urandom_range(130) - 65;
         end
         8: for (int i = 0; i < 8; i++) if ($urandom_range(1)) q[i] = corner_coord();
         9: begin  // shared endpoint
            q[4] = q[2]; q[5] = q[3];
         end
         default: ;
      endcase
   endfunction

   task automatic test_directed();
      query_type q;
      // crossing diagonals
      q = '{0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0}; send_query(q);
      // parallel
      q = '{0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000}; send_query(q);
      // collinear overlap
      q = '{0, 0, 32'h20000, 0, 32'h10000, 0, 32'h30000, 0}; send_query(q);
      // lines cross beyond segment a
      q = '{0, 0, 32'h10000, 0, 32'h30000, -32'sh10000, 32'h30000, 32'h10000}; send_query(q);
      // touching at endpoints
      q = '{0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 0}; send_query(q);
      // degenerate point segment
      q = '{32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 32'h20000, 32'h20000};
      send_query(q);
      // extremes: huge spans, saturating results
      q = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}; send_query(q);
      q = '{0, 0, 1, 32'h100, 0, 32'h7fff_ffff, 32'h100, 32'h7fff_fff0}; send_query(q);
      q = '{32'h7fff_ffff, 0, 32'h7fff_fffe, 32'h100, 0, 0, 32'h100, 1}; send_query(q);
      // determinant just above and just below the parallel threshold
      q = '{0, 0, 32'h10000, 0, 0, 0, 66, 66}; send_query(q);
      q = '{0, 0, 32'h10000, 0, 0, 0, 0, 65}; send_query(q);
      // extents at and just above the tiny limit
      q = '{0, 0, 65, 65, -32'sh10000, 32'h10000, 32'h10000, -32'sh10000}; send_query(q);
      q = '{0, 0, 66, 0, 33, -32'sh10000, 33, 32'h10000}; send_query(q);
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 8; j++) q[j] = corner_coord();
         send_query(q);
      end
   endtask

   task automatic test_random(int count);
      query_type q;
      for (int i = 0; i < count; i++) begin
         random_query(q);
         send_query(q);
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_directed();
      write_mode(1'b0);
      test_directed();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 73 : 0;
         recv_stall_pct = (phase == 0) ? 73 : (phase == 1) ? 15 : 0;
         write_mode(1'b1);
         test_random(120);
         write_mode(1'b0);
         test_random(100);
      end
      wait_idle();
      $display("Ran %0d queries in both modes under three stall patterns:", query_count);
      $display("  %0d hits, %0d parallel, %0d outside", hit_count, parallel_count,
               outside_count);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
